// ===== hw/rtl/bundle_relocation_patcher_unit_defines.svh =====
// Assertion macros shared by the bundle relocation patcher RTL.
`ifndef BUNDLE_RELOCATION_PATCHER_UNIT_DEFINES_SVH
`define BUNDLE_RELOCATION_PATCHER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define BRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brp: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define BRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brp: next-cycle check failed");
`else
`define BRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/brp_pkg.sv =====
// Types, operand form codes and status codes of the bundle relocation patcher.
`timescale 1ns / 1ps
package brp_pkg;

    // Operand forms
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_IMM14     = 4'd1;
    localparam logic [3:0] OP_IMM22     = 4'd2;
    localparam logic [3:0] OP_TGT25     = 4'd3;
    localparam logic [3:0] OP_TGT25B    = 4'd4;
    localparam logic [3:0] OP_TGT25C    = 4'd5;
    localparam logic [3:0] OP_IMM64     = 4'd6;
    localparam logic [3:0] OP_TGT64     = 4'd7;
    localparam logic [3:0] OP_DATA32_BE = 4'd8;
    localparam logic [3:0] OP_DATA32_LE = 4'd9;
    localparam logic [3:0] OP_DATA64_BE = 4'd10;
    localparam logic [3:0] OP_DATA64_LE = 4'd11;

    // Status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_BAD_SLOT    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW    = 2'd3;

    // Slot codes
    localparam logic [1:0] SLOT_0       = 2'd0;
    localparam logic [1:0] SLOT_1       = 2'd1;
    localparam logic [1:0] SLOT_2       = 2'd2;
    localparam logic [1:0] SLOT_INVALID = 2'd3;

    localparam int unsigned SYL_W = 41;
    localparam int unsigned WIN_W = 128;

    typedef struct packed {
        logic [3:0]  operation;
        logic [1:0]  slot;
        logic [63:0] value;
        logic [63:0] window_low;
        logic [63:0] window_high;
    } t_brp_req;

    typedef struct packed {
        logic [63:0] patched_low;
        logic [63:0] patched_high;
        logic [1:0]  status;
    } t_brp_rsp;

    // Result of the 41-bit slot path
    typedef struct packed {
        logic             fits;
        logic [WIN_W-1:0] window;
    } t_brp_slot_res;

endpackage

// ===== hw/rtl/brp_slot_patch.sv =====
// Slot operand path: extract a syllable, range check, scatter the operand, reinsert.
`timescale 1ns / 1ps
module brp_slot_patch (
    input  logic [3:0]              i_operation,
    input  logic [1:0]              i_slot,
    input  logic [63:0]             i_value,
    input  logic [63:0]             i_window_low,
    input  logic [63:0]             i_window_high,
    output brp_pkg::t_brp_slot_res  o_res
);
    import brp_pkg::*;

    logic [WIN_W-1:0] win;
    logic [SYL_W-1:0] syl;
    logic [SYL_W-1:0] clr;
    logic [SYL_W-1:0] ins;
    logic [SYL_W-1:0] syl_new;
    logic             fits;
    logic             sgn;

    assign win = {i_window_high, i_window_low};
    assign sgn = i_value[63];

    // Pick the syllable of the chosen slot.
    always_comb begin
        unique case (i_slot)
            SLOT_0:  syl = win[45:5];
            SLOT_1:  syl = win[86:46];
            SLOT_2:  syl = win[127:87];
            default: syl = '0;
        endcase
    end

    // Operand field layout and range check per form.
    always_comb begin
        clr  = '0;
        ins  = '0;
        fits = 1'b1;
        unique case (i_operation)
            OP_IMM14: begin
                fits        = (i_value[63:13] == {51{sgn}});
                clr[19:13]  = '1;
                clr[32:27]  = '1;
                clr[36]     = 1'b1;
                ins[19:13]  = i_value[6:0];
                ins[32:27]  = i_value[12:7];
                ins[36]     = i_value[13];
            end
            OP_IMM22: begin
                fits        = (i_value[63:21] == {43{sgn}});
                clr[19:13]  = '1;
                clr[35:27]  = '1;
                clr[26:22]  = '1;
                clr[36]     = 1'b1;
                ins[19:13]  = i_value[6:0];
                ins[35:27]  = i_value[15:7];
                ins[26:22]  = i_value[20:16];
                ins[36]     = i_value[21];
            end
            OP_TGT25: begin
                fits        = (i_value[63:24] == {40{sgn}});
                clr[25:6]   = '1;
                clr[36]     = 1'b1;
                ins[25:6]   = i_value[23:4];
                ins[36]     = i_value[24];
            end
            OP_TGT25B: begin
                fits        = (i_value[63:24] == {40{sgn}});
                clr[12:6]   = '1;
                clr[32:20]  = '1;
                clr[36]     = 1'b1;
                ins[12:6]   = i_value[10:4];
                ins[32:20]  = i_value[23:11];
                ins[36]     = i_value[24];
            end
            OP_TGT25C: begin
                fits        = (i_value[63:24] == {40{sgn}});
                clr[32:13]  = '1;
                clr[36]     = 1'b1;
                ins[32:13]  = i_value[23:4];
                ins[36]     = i_value[24];
            end
            default: begin
                fits = 1'b1;
            end
        endcase
    end

    assign syl_new = (syl & ~clr) | ins;

    // Put the syllable back.
    always_comb begin
        o_res.fits   = fits;
        o_res.window = win;
        unique case (i_slot)
            SLOT_0:  o_res.window[45:5]   = syl_new;
            SLOT_1:  o_res.window[86:46]  = syl_new;
            SLOT_2:  o_res.window[127:87] = syl_new;
            default: o_res.window         = win;
        endcase
    end

endmodule

// ===== hw/rtl/brp_fixed_patch.sv =====
// Long (movl, brl) and data forms: fixed-position scatter of the value.
`timescale 1ns / 1ps
module brp_fixed_patch (
    input  logic [3:0]  i_operation,
    input  logic [63:0] i_value,
    input  logic [63:0] i_window_low,
    input  logic [63:0] i_window_high,
    output logic [63:0] o_patched_low,
    output logic [63:0] o_patched_high
);
    import brp_pkg::*;

    logic [63:0] swapped;

    assign swapped = {i_value[7:0],   i_value[15:8],  i_value[23:16], i_value[31:24],
                      i_value[39:32], i_value[47:40], i_value[55:48], i_value[63:56]};

    always_comb begin
        o_patched_low  = i_window_low;
        o_patched_high = i_window_high;
        unique case (i_operation)
            OP_IMM64: begin
                o_patched_low[63:46]  = i_value[39:22];
                o_patched_high[22:0]  = i_value[62:40];
                o_patched_high[42:36] = i_value[6:0];
                o_patched_high[58:50] = i_value[15:7];
                o_patched_high[49:45] = i_value[20:16];
                o_patched_high[44]    = i_value[21];
                o_patched_high[59]    = i_value[63];
            end
            OP_TGT64: begin
                o_patched_low[63:48]  = i_value[39:24];
                o_patched_low[47:46]  = 2'b00;
                o_patched_high[22:0]  = i_value[62:40];
                o_patched_high[55:36] = i_value[23:4];
                o_patched_high[59]    = i_value[63];
            end
            OP_DATA32_BE: o_patched_low[31:0] = swapped[63:32];
            OP_DATA32_LE: o_patched_low[31:0] = i_value[31:0];
            OP_DATA64_BE: o_patched_low       = swapped;
            OP_DATA64_LE: o_patched_low       = i_value;
            default: begin
                o_patched_low  = i_window_low;
                o_patched_high = i_window_high;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bundle_relocation_patcher_unit.sv =====
// Top level of the bundle relocation patcher: request register, patch logic, result register.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                payload
//  request   in         i_in_valid / o_in_stall   i_in_req  (t_brp_req)
//  result    out        o_out_valid / i_out_stall o_out_rsp (t_brp_rsp)
//
//  One request per cycle while no stall holds the flow; a taken request passes the request register,
//  then the result register, where its result is offered. Throughput is set by the single pass between them.
//  Synchronous active-low reset empties both registers; payload bits are not reset.
//  A stalled result holds; the request register still takes a request while it is empty.
//
`include "bundle_relocation_patcher_unit_defines.svh"
module bundle_relocation_patcher_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  brp_pkg::t_brp_req i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output brp_pkg::t_brp_rsp o_out_rsp
);
    import brp_pkg::*;

    // Request register
    logic          r_s1_valid;
    t_brp_req      r_s1_req;
    // Result register
    logic          r_out_valid;
    t_brp_rsp      r_out_rsp;

    logic          s1_stall;
    logic          s1_fire;
    logic          n_s1_valid;
    logic          n_out_valid;
    t_brp_rsp      n_out_rsp;
    logic [1:0]    n_status;

    t_brp_slot_res slot_res;
    logic [63:0]   fixed_low;
    logic [63:0]   fixed_high;

    // Hold the request register while the result register is full and stalled.
    assign s1_stall   = r_out_valid && i_out_stall;
    assign o_in_stall = r_s1_valid && s1_stall;
    // Advance the held request into the result register.
    assign s1_fire    = r_s1_valid && !s1_stall;

    assign n_s1_valid  = o_in_stall ? r_s1_valid : i_in_valid;
    assign n_out_valid = s1_stall ? r_out_valid : r_s1_valid;

    // Patch datapaths
    brp_slot_patch u_slot (
        .i_operation   (r_s1_req.operation),
        .i_slot        (r_s1_req.slot),
        .i_value       (r_s1_req.value),
        .i_window_low  (r_s1_req.window_low),
        .i_window_high (r_s1_req.window_high),
        .o_res         (slot_res)
    );

    brp_fixed_patch u_fixed (
        .i_operation    (r_s1_req.operation),
        .i_value        (r_s1_req.value),
        .i_window_low   (r_s1_req.window_low),
        .i_window_high  (r_s1_req.window_high),
        .o_patched_low  (fixed_low),
        .o_patched_high (fixed_high)
    );

    // Status decode: slot forms need slots zero to two, long forms need slot one.
    always_comb begin
        unique case (r_s1_req.operation) inside
            OP_NONE, OP_DATA32_BE, OP_DATA32_LE, OP_DATA64_BE, OP_DATA64_LE: begin
                n_status = ST_OK;
            end
            [OP_IMM14:OP_TGT25C]: begin
                if (r_s1_req.slot == SLOT_INVALID) begin
                    n_status = ST_BAD_SLOT;
                end else if (!slot_res.fits) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_status = ST_OK;
                end
            end
            OP_IMM64, OP_TGT64: begin
                n_status = (r_s1_req.slot == SLOT_1) ? ST_OK : ST_BAD_SLOT;
            end
            default: begin
                n_status = ST_UNSUPPORTED;
            end
        endcase
    end

    // Select the patched window; drop all changes on a non-OK status.
    always_comb begin
        n_out_rsp.status       = n_status;
        n_out_rsp.patched_low  = r_s1_req.window_low;
        n_out_rsp.patched_high = r_s1_req.window_high;
        if (n_status == ST_OK) begin
            case (r_s1_req.operation) inside
                [OP_IMM14:OP_TGT25C]: begin
                    n_out_rsp.patched_low  = slot_res.window[63:0];
                    n_out_rsp.patched_high = slot_res.window[127:64];
                end
                [OP_IMM64:OP_DATA64_LE]: begin
                    n_out_rsp.patched_low  = fixed_low;
                    n_out_rsp.patched_high = fixed_high;
                end
                default: begin
                    n_out_rsp.patched_low  = r_s1_req.window_low;
                    n_out_rsp.patched_high = r_s1_req.window_high;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: load on transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_req <= i_in_req;
        end
        if (s1_fire) begin
            r_out_rsp <= n_out_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // A request is only stalled while the request register is occupied.
    `BRP_ASSERT_IMP(a_stall_needs_occupant, i_clk, i_rst_n, o_in_stall, r_s1_valid)
    // A stalled request stays in place.
    `BRP_ASSERT_NXT(a_s1_holds, i_clk, i_rst_n, r_s1_valid && s1_stall, r_s1_valid)
    // A failed patch leaves the window untouched.
    `BRP_ASSERT_NXT(a_fail_keeps_window, i_clk, i_rst_n, s1_fire && n_status != ST_OK,
        r_out_rsp.patched_low == $past(r_s1_req.window_low) &&
        r_out_rsp.patched_high == $past(r_s1_req.window_high))
    // Long forms outside slot one report a bad slot.
    `BRP_ASSERT_NXT(a_long_bad_slot, i_clk, i_rst_n,
        s1_fire && (r_s1_req.operation == OP_IMM64 || r_s1_req.operation == OP_TGT64) &&
        r_s1_req.slot != SLOT_1, r_out_rsp.status == ST_BAD_SLOT)

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the bundle relocation patcher: directed table, then random requests.
`timescale 1ns / 1ps
module testbench;
    import brp_pkg::*;

    // Forms twelve through fifteen carry no name in the package.
    localparam logic [3:0] OP_UNSUP_LO = 4'd12;
    localparam logic [3:0] OP_UNSUP_HI = 4'd15;

    localparam int unsigned RANDOM_REQUESTS = 1600;
    localparam int unsigned DRAIN_CYCLES    = 8;     // a result passes the request and result registers
    localparam int unsigned QUIET_LIMIT     = 4000;  // cycles with no handshake on either side
    localparam int unsigned PRESSURE_AT     = 400;   // result count that triggers the long hold
    localparam int unsigned PRESSURE_HOLD   = 300;
    localparam int unsigned REPORT_CAP      = 30;

    localparam logic [63:0] WIN_A_LO = 64'h0123_4567_89ab_cdef;
    localparam logic [63:0] WIN_A_HI = 64'hfedc_ba98_7654_3210;
    localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

    typedef struct {
        t_brp_req req;
        bit       typed;  // expected result written in the table, not predicted
        t_brp_rsp want;
    } t_patch_vector;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_brp_req i_in_req    = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_brp_rsp o_out_rsp;

    t_brp_rsp      pending_patches[$];
    t_patch_vector patch_vectors[$];
    int unsigned   requests_sent   = 0;
    int unsigned   results_checked = 0;
    int unsigned   mismatches      = 0;
    int unsigned   status_seen[4]  = '{0, 0, 0, 0};
    int unsigned   quiet_cycles    = 0;
    bit            in_calm         = 1'b0;

    bundle_relocation_patcher_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] byte_reverse(input logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 8; i++) y[8*i +: 8] = x[8*(7-i) +: 8];
        return y;
    endfunction

    // Compute the patched window and status for one request.
    function automatic t_brp_rsp patch_window(input t_brp_req r);
        logic [127:0] win;
        logic [63:0]  v, lo, hi, t, s, clr, ins, top, want, syl;
        int unsigned  p, sc, nf, total, sh;
        int unsigned  fb[4];
        int unsigned  fp[4];
        logic [1:0]   st;
        t_brp_rsp     res;
        v  = r.value;
        lo = r.window_low;
        hi = r.window_high;
        st = ST_OK;
        sc = 0;
        nf = 0;
        fb = '{0, 0, 0, 0};
        fp = '{0, 0, 0, 0};
        case (r.operation)
            OP_NONE: begin
            end
            OP_IMM14, OP_IMM22, OP_TGT25, OP_TGT25B, OP_TGT25C: begin
                // Field list per form: widths and positions, least significant field first.
                case (r.operation)
                    OP_IMM14: begin
                        sc = 0; nf = 3; fb = '{7, 6, 1, 0};  fp = '{13, 27, 36, 0};
                    end
                    OP_IMM22: begin
                        sc = 0; nf = 4; fb = '{7, 9, 5, 1};  fp = '{13, 27, 22, 36};
                    end
                    OP_TGT25: begin
                        sc = 4; nf = 2; fb = '{20, 1, 0, 0}; fp = '{6, 36, 0, 0};
                    end
                    OP_TGT25B: begin
                        sc = 4; nf = 3; fb = '{7, 13, 1, 0}; fp = '{6, 20, 36, 0};
                    end
                    default: begin
                        sc = 4; nf = 2; fb = '{20, 1, 0, 0}; fp = '{13, 36, 0, 0};
                    end
                endcase
                if (r.slot == SLOT_INVALID) begin
                    st = ST_BAD_SLOT;
                end else begin
                    p     = 5 + 41 * r.slot;
                    win   = {hi, lo};
                    syl   = 64'(win[p +: 41]);
                    total = 0;
                    clr   = '0;
                    ins   = '0;
                    for (int k = 0; k < nf; k++) begin
                        total += fb[k];
                        clr |= ((64'd1 << fb[k]) - 64'd1) << fp[k];
                    end
                    // Range check: the bits above the signed field must all equal the sign.
                    sh   = sc + total - 1;
                    top  = v >> sh;
                    want = v[63] ? (ALL_ONES >> sh) : 64'd0;
                    if (top != want) begin
                        st = ST_OVERFLOW;
                    end else begin
                        s = v >> sc;
                        for (int k = 0; k < nf; k++) begin
                            ins |= (s & ((64'd1 << fb[k]) - 64'd1)) << fp[k];
                            s = s >> fb[k];
                        end
                        syl = (syl & ~clr) | ins;
                        win[p +: 41] = syl[40:0];
                        lo = win[63:0];
                        hi = win[127:64];
                    end
                end
            end
            OP_IMM64: begin
                if (r.slot != SLOT_1) begin
                    st = ST_BAD_SLOT;
                end else begin
                    lo = lo & ~(64'h3ffff << 46);
                    hi = hi & ~(64'h7fffff | (((64'h7f << 13) | (64'h1ff << 27) |
                                (64'h1f << 22) | (64'd1 << 21) | (64'd1 << 36)) << 23));
                    lo = lo | (((v >> 22) & 64'h3ffff) << 46);
                    hi = hi | ((v >> 40) & 64'h7fffff);
                    hi = hi | ((((v & 64'h7f) << 13) | (((v >> 7) & 64'h1ff) << 27) |
                                (((v >> 16) & 64'h1f) << 22) | (((v >> 21) & 64'd1) << 21) |
                                (((v >> 63) & 64'd1) << 36)) << 23);
                end
            end
            OP_TGT64: begin
                if (r.slot != SLOT_1) begin
                    st = ST_BAD_SLOT;
                end else begin
                    t  = v >> 4;
                    lo = lo & ~(64'h3ffff << 46);
                    hi = hi & ~(64'h7fffff | (((64'd1 << 36) | (64'hfffff << 13)) << 23));
                    lo = lo | (((t >> 20) & 64'hffff) << 48);
                    hi = hi | ((t >> 36) & 64'h7fffff);
                    hi = hi | ((((t & 64'hfffff) << 13) | (((t >> 59) & 64'd1) << 36)) << 23);
                end
            end
            OP_DATA32_BE: begin
                t  = byte_reverse(v);
                lo = {lo[63:32], t[63:32]};
            end
            OP_DATA32_LE: lo = {lo[63:32], v[31:0]};
            OP_DATA64_BE: lo = byte_reverse(v);
            OP_DATA64_LE: lo = v;
            default:      st = ST_UNSUPPORTED;
        endcase
        // Any error returns the window untouched.
        if (st != ST_OK) begin
            lo = r.window_low;
            hi = r.window_high;
        end
        res.patched_low  = lo;
        res.patched_high = hi;
        res.status       = st;
        return res;
    endfunction

    task automatic add_vector(input logic [3:0] op, input logic [1:0] slot,
                              input logic [63:0] v, input logic [63:0] lo,
                              input logic [63:0] hi, input bit typed,
                              input logic [63:0] want_lo, input logic [63:0] want_hi,
                              input logic [1:0] want_st);
        t_patch_vector pv;
        pv.req.operation      = op;
        pv.req.slot           = slot;
        pv.req.value          = v;
        pv.req.window_low     = lo;
        pv.req.window_high    = hi;
        pv.typed              = typed;
        pv.want.patched_low   = want_lo;
        pv.want.patched_high  = want_hi;
        pv.want.status        = want_st;
        patch_vectors.push_back(pv);
    endtask

    // Build a random request: half of them slot forms, with values near their signed range.
    function automatic t_brp_req random_request();
        t_brp_req    r;
        logic [63:0] raw;
        int unsigned pick, nb, sh;
        pick = $urandom_range(0, 99);
        if (pick < 50)      r.operation = 4'($urandom_range(OP_IMM14, OP_TGT25C));
        else if (pick < 65) r.operation = 4'($urandom_range(OP_IMM64, OP_TGT64));
        else if (pick < 85) r.operation = 4'($urandom_range(OP_DATA32_BE, OP_DATA64_LE));
        else if (pick < 92) r.operation = OP_NONE;
        else                r.operation = 4'($urandom_range(OP_UNSUP_LO, OP_UNSUP_HI));

        if ((r.operation == OP_IMM64 || r.operation == OP_TGT64) && $urandom_range(0, 9) < 8)
            r.slot = SLOT_1;
        else if ($urandom_range(0, 9) == 0)
            r.slot = SLOT_INVALID;
        else
            r.slot = 2'($urandom_range(SLOT_0, SLOT_2));

        case (r.operation)
            OP_IMM14:                      nb = 14;
            OP_IMM22:                      nb = 22;
            OP_TGT25, OP_TGT25B, OP_TGT25C: nb = 25;
            default:                       nb = 64;
        endcase
        raw  = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (nb < 64 && pick == 0) begin
            // Land exactly on the signed extremes.
            raw = (64'd1 << (nb - 1)) - 64'd1;
            r.value = $urandom_range(0, 1) ? raw : ~raw;
        end else begin
            if (nb < 64 && pick < 7)      sh = 64 - nb;
            else if (nb < 64 && pick < 9) sh = 64 - nb - $urandom_range(1, 3);
            else                          sh = 0;
            r.value = 64'($signed(raw << sh) >>> sh);
        end
        r.window_low  = ($urandom_range(0, 15) == 0) ? ALL_ONES : {$urandom, $urandom};
        r.window_high = ($urandom_range(0, 15) == 0) ? ALL_ONES : {$urandom, $urandom};
        return r;
    endfunction

    // Offer one request after a random gap; hold it until taken, then queue its result.
    task automatic offer_request(input t_brp_req req, input t_brp_rsp want);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        gap = in_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (o_in_stall);
        pending_patches.push_back(want);
        requests_sent++;
    endtask

    // Result side: check each accepted result, then stall for a drawn number of cycles.
    initial begin : result_sink
        t_brp_rsp    want;
        int unsigned hold_left;
        bit          out_calm;
        hold_left = 0;
        out_calm  = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                status_seen[o_out_rsp.status]++;
                if (pending_patches.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t: result with no request outstanding: %h %h status %0d",
                                 $time, o_out_rsp.patched_low, o_out_rsp.patched_high,
                                 o_out_rsp.status);
                end else begin
                    want = pending_patches.pop_front();
                    if (o_out_rsp.patched_low !== want.patched_low) begin
                        mismatches++;
                        if (mismatches <= REPORT_CAP)
                            $display("%0t: patched_low expected %h, got %h", $time,
                                     want.patched_low, o_out_rsp.patched_low);
                    end
                    if (o_out_rsp.patched_high !== want.patched_high) begin
                        mismatches++;
                        if (mismatches <= REPORT_CAP)
                            $display("%0t: patched_high expected %h, got %h", $time,
                                     want.patched_high, o_out_rsp.patched_high);
                    end
                    if (o_out_rsp.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= REPORT_CAP)
                            $display("%0t: status expected %0d, got %0d", $time,
                                     want.status, o_out_rsp.status);
                    end
                end
                results_checked++;
                if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
                hold_left = out_calm ? 0 : $urandom_range(0, 17);
                // Hold off long enough once for the block to fill and stall its input.
                if (results_checked == PRESSURE_AT) hold_left = PRESSURE_HOLD;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: drop the run when neither channel has moved for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : request_source
        t_brp_req req;
        // Typed rows: error paths, form none and the data forms, readable by eye.
        add_vector(OP_NONE, SLOT_INVALID, ALL_ONES, WIN_A_LO, WIN_A_HI,
                   1'b1, WIN_A_LO, WIN_A_HI, ST_OK);
        add_vector(OP_UNSUP_LO, SLOT_0, ALL_ONES, WIN_A_LO, WIN_A_HI,
                   1'b1, WIN_A_LO, WIN_A_HI, ST_UNSUPPORTED);
        add_vector(OP_UNSUP_HI, SLOT_1, 64'd0, ALL_ONES, ALL_ONES,
                   1'b1, ALL_ONES, ALL_ONES, ST_UNSUPPORTED);
        add_vector(OP_IMM64, SLOT_0, ALL_ONES, WIN_A_LO, WIN_A_HI,
                   1'b1, WIN_A_LO, WIN_A_HI, ST_BAD_SLOT);
        add_vector(OP_TGT64, SLOT_2, ALL_ONES, WIN_A_LO, WIN_A_HI,
                   1'b1, WIN_A_LO, WIN_A_HI, ST_BAD_SLOT);
        add_vector(OP_IMM64, SLOT_INVALID, 64'd0, WIN_A_LO, WIN_A_HI,
                   1'b1, WIN_A_LO, WIN_A_HI, ST_BAD_SLOT);
        add_vector(OP_IMM14, SLOT_INVALID, 64'd1, WIN_A_LO, WIN_A_HI,
                   1'b1, WIN_A_LO, WIN_A_HI, ST_BAD_SLOT);
        add_vector(OP_TGT25C, SLOT_INVALID, 64'd0, ALL_ONES, WIN_A_HI,
                   1'b1, ALL_ONES, WIN_A_HI, ST_BAD_SLOT);
        add_vector(OP_DATA64_LE, SLOT_INVALID, 64'h1122_3344_5566_7788, WIN_A_LO, WIN_A_HI,
                   1'b1, 64'h1122_3344_5566_7788, WIN_A_HI, ST_OK);
        add_vector(OP_DATA64_BE, SLOT_0, 64'h0102_0304_0506_0708, WIN_A_LO, WIN_A_HI,
                   1'b1, 64'h0807_0605_0403_0201, WIN_A_HI, ST_OK);
        add_vector(OP_DATA32_LE, SLOT_2, 64'hdead_beef_cafe_f00d, WIN_A_LO, WIN_A_HI,
                   1'b1, 64'h0123_4567_cafe_f00d, WIN_A_HI, ST_OK);
        add_vector(OP_DATA32_BE, SLOT_1, 64'hdead_beef_1122_3344, WIN_A_LO, WIN_A_HI,
                   1'b1, 64'h0123_4567_4433_2211, WIN_A_HI, ST_OK);
        // Operand range edges: inside goes to the predictor, outside is typed.
        add_vector(OP_IMM14, SLOT_0, 64'd8191, WIN_A_LO, WIN_A_HI, 1'b0, '0, '0, ST_OK);
        add_vector(OP_IMM14, SLOT_2, 64'hffff_ffff_ffff_e000, WIN_A_LO, WIN_A_HI,
                   1'b0, '0, '0, ST_OK);
        add_vector(OP_IMM14, SLOT_1, 64'd8192, WIN_A_LO, WIN_A_HI,
                   1'b1, WIN_A_LO, WIN_A_HI, ST_OVERFLOW);
        add_vector(OP_IMM14, SLOT_0, 64'hffff_ffff_ffff_dfff, WIN_A_LO, WIN_A_HI,
                   1'b1, WIN_A_LO, WIN_A_HI, ST_OVERFLOW);
        add_vector(OP_IMM22, SLOT_1, 64'h1f_ffff, ALL_ONES, ALL_ONES, 1'b0, '0, '0, ST_OK);
        add_vector(OP_IMM22, SLOT_2, 64'hffff_ffff_ffe0_0000, 64'd0, 64'd0,
                   1'b0, '0, '0, ST_OK);
        add_vector(OP_TGT25, SLOT_2, 64'hff_ffff, WIN_A_LO, WIN_A_HI, 1'b0, '0, '0, ST_OK);
        add_vector(OP_TGT25, SLOT_0, 64'h100_0000, WIN_A_LO, WIN_A_HI,
                   1'b1, WIN_A_LO, WIN_A_HI, ST_OVERFLOW);
        add_vector(OP_TGT25B, SLOT_0, 64'hffff_ffff_ff00_0000, ALL_ONES, ALL_ONES,
                   1'b0, '0, '0, ST_OK);
        add_vector(OP_TGT25C, SLOT_1, 64'h8000_0000_0000_0000, WIN_A_LO, WIN_A_HI,
                   1'b1, WIN_A_LO, WIN_A_HI, ST_OVERFLOW);
        add_vector(OP_TGT25C, SLOT_2, 64'hffff_ffff_ff00_000f, WIN_A_LO, WIN_A_HI,
                   1'b0, '0, '0, ST_OK);
        // Long forms: full-scale values into opposite windows.
        add_vector(OP_IMM64, SLOT_1, ALL_ONES, 64'd0, 64'd0, 1'b0, '0, '0, ST_OK);
        add_vector(OP_TGT64, SLOT_1, 64'h8000_0000_0000_000f, ALL_ONES, ALL_ONES,
                   1'b0, '0, '0, ST_OK);

        // Hold reset at the start, then release it for good.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (patch_vectors[i])
            offer_request(patch_vectors[i].req,
                          patch_vectors[i].typed ? patch_vectors[i].want
                                                 : patch_window(patch_vectors[i].req));

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            req = random_request();
            offer_request(req, patch_window(req));
        end
        i_in_valid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle before the summary.
        while (pending_patches.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d directed), checked %0d results, %0d mismatches.",
                 requests_sent, patch_vectors.size(), results_checked, mismatches);
        $display("Status mix: ok %0d, unsupported %0d, bad slot %0d, overflow %0d.",
                 status_seen[ST_OK], status_seen[ST_UNSUPPORTED],
                 status_seen[ST_BAD_SLOT], status_seen[ST_OVERFLOW]);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/brp_pkg.sv
hw/rtl/brp_slot_patch.sv
hw/rtl/brp_fixed_patch.sv
hw/rtl/bundle_relocation_patcher_unit.sv
dv/testbench.sv
